[hw/rtl/id3v2_frame_text_extractor_core_assert.svh]
// ----------------------------------------------------------------------------
// ID3v2 frame text extractor assertion macros
// Shared concurrent assertion forms, clocked on clk; ID3FTE_ASSERT uses rst as disable.
// ----------------------------------------------------------------------------
`ifndef ID3V2_FRAME_TEXT_EXTRACTOR_CORE_ASSERT_SVH
`define ID3V2_FRAME_TEXT_EXTRACTOR_CORE_ASSERT_SVH

// check a property outside reset
`define ID3FTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define ID3FTE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/id3fte_pkg.sv]
// ----------------------------------------------------------------------------
// ID3v2 frame text extractor package
// Types, codes and constants shared by the parser and the result queue.
// ----------------------------------------------------------------------------
package id3fte_pkg;

  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);

  localparam logic [31:0] LongKeyReset  = 32'd1414091826;
  localparam logic [23:0] ShortKeyReset = 24'd5526578;

  localparam logic [0:0] RegLongKey  = 1'd0;
  localparam logic [0:0] RegShortKey = 1'd1;

  localparam logic [1:0] OC_FOUND     = 2'd0;
  localparam logic [1:0] OC_ABSENT    = 2'd1;
  localparam logic [1:0] OC_NO_MAGIC  = 2'd2;
  localparam logic [1:0] OC_TRUNCATED = 2'd3;

  typedef enum logic [5:0] {
    PH_HDR     = 6'b000001,
    PH_EXT     = 6'b000010,
    PH_FHDR    = 6'b000100,
    PH_PAY     = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_NOMAGIC = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] text_char;
    logic [1:0] outcome;
    logic [7:0] tag_version;
  } result_t;

  typedef struct packed {
    logic    r0_valid;
    result_t r0;
    logic    r1_valid;
    result_t r1;
  } push_t;

endpackage

[hw/rtl/id3v2_frame_text_extractor_core.sv]
// ----------------------------------------------------------------------------
// ID3v2 frame text extractor core
// Walks an ID3v2 tag a byte at a time and emits the text of the keyed frame,
// then a status word at the end of the data.
//
//   channel   signals                                   role
//   in        in_valid/in_ready, tag_byte, end_of_data  tag bytes
//   out       out_valid/out_ready, is_status .. version  text and status words
//   cfg       cfg_write, cfg_index, cfg_data            frame keys
//
// One byte is accepted per cycle while there is room; its words are queued.
// A byte yields at most two words, so a stalled output throttles input once
// the four-word result queue has fewer than two free slots.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`include "id3v2_frame_text_extractor_core_assert.svh"

module id3v2_frame_text_extractor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  tag_byte,
  input  logic        end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_status,
  output logic [7:0]  text_char,
  output logic [1:0]  outcome,
  output logic [7:0]  tag_version
);

  id3fte_pkg::push_t                push;
  id3fte_pkg::result_t              head_word;
  logic [id3fte_pkg::CountW-1:0]    count;
  logic                             fire;

  assign fire = in_valid && in_ready;

  id3fte_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fire        (fire),
    .tag_byte    (tag_byte),
    .end_of_data (end_of_data),
    .push        (push)
  );

  id3fte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_word (head_word),
    .count     (count)
  );

  assign is_status   = head_word.is_status;
  assign text_char   = head_word.text_char;
  assign outcome     = head_word.outcome;
  assign tag_version = head_word.tag_version;

  `ID3FTE_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0), "queue not empty after reset")
  `ID3FTE_ASSERT(a_status_queued, (fire && end_of_data) |=> out_valid, "status word missing")
  `ID3FTE_ASSERT(a_depth, count <= id3fte_pkg::CountW'(id3fte_pkg::QueueDepth), "queue overrun")
  `ID3FTE_ASSERT(a_hold, (out_valid && !out_ready && !fire) |=> $stable(head_word), "word moved")

endmodule

[hw/rtl/id3fte_parser.sv]
// ----------------------------------------------------------------------------
// ID3v2 frame text extractor parser
// Holds the walk state and works out one byte's results in a single pass.
// ----------------------------------------------------------------------------
module id3fte_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                fire,
  input  logic [7:0]          tag_byte,
  input  logic                end_of_data,
  output id3fte_pkg::push_t   push
);

  logic [31:0] long_key;
  logic [23:0] short_key;

  id3fte_pkg::phase_t phase, phase_next;
  logic [3:0]  header_index, header_index_next;
  logic [7:0]  major_version, major_version_next;
  logic        unsync_on, unsync_on_next;
  logic        ext_header_on, ext_header_on_next;
  logic [27:0] tag_bytes_left, tag_bytes_left_next;
  logic [27:0] ext_bytes_left, ext_bytes_left_next;
  logic        last_was_ff, last_was_ff_next;
  logic [3:0]  frame_header_index, frame_header_index_next;
  logic [31:0] frame_id_shift, frame_id_shift_next;
  logic [31:0] frame_length, frame_length_next;
  logic [27:0] payload_index, payload_index_next;
  logic [7:0]  text_encoding, text_encoding_next;
  logic        text_done, text_done_next;
  logic        match_found, match_found_next;
  logic [1:0]  done_code, done_code_next;

  always_comb begin
    logic        shortv;
    logic [3:0]  idlen;
    logic [3:0]  hsize;
    logic [3:0]  idx;
    logic        deliver;
    logic        plain;
    logic        take;
    logic [1:0]  oc;
    phase_next              = phase;
    header_index_next       = header_index;
    major_version_next      = major_version;
    unsync_on_next          = unsync_on;
    ext_header_on_next      = ext_header_on;
    tag_bytes_left_next     = tag_bytes_left;
    ext_bytes_left_next     = ext_bytes_left;
    last_was_ff_next        = last_was_ff;
    frame_header_index_next = frame_header_index;
    frame_id_shift_next     = frame_id_shift;
    frame_length_next       = frame_length;
    payload_index_next      = payload_index;
    text_encoding_next      = text_encoding;
    text_done_next          = text_done;
    match_found_next        = match_found;
    done_code_next          = done_code;
    push                    = '0;
    shortv  = major_version < 8'd3;
    idlen   = shortv ? 4'd3 : 4'd4;
    hsize   = shortv ? 4'd6 : 4'd10;
    idx     = '0;
    deliver = 1'b1;
    plain   = 1'b0;
    take    = 1'b0;
    oc      = id3fte_pkg::OC_FOUND;

    unique case (phase)
      id3fte_pkg::PH_HDR: begin
        idx = header_index;
        if (idx == 4'd0) begin
          if (tag_byte != 8'h49) phase_next = id3fte_pkg::PH_NOMAGIC;
        end else if (idx == 4'd1) begin
          if (tag_byte != 8'h44) phase_next = id3fte_pkg::PH_NOMAGIC;
        end else if (idx == 4'd2) begin
          if (tag_byte != 8'h33) phase_next = id3fte_pkg::PH_NOMAGIC;
        end else if (idx == 4'd3) begin
          major_version_next = tag_byte;
        end else if (idx == 4'd5) begin
          unsync_on_next     = tag_byte[7];
          ext_header_on_next = tag_byte[6];
        end else if (idx >= 4'd6) begin
          tag_bytes_left_next = {tag_bytes_left[20:0], tag_byte[6:0]};
        end
        header_index_next = idx + 4'd1;
        if (phase_next == id3fte_pkg::PH_HDR && idx == 4'd9) begin
          header_index_next = '0;
          if (tag_bytes_left_next == '0) begin
            phase_next     = id3fte_pkg::PH_DONE;
            done_code_next = id3fte_pkg::OC_ABSENT;
          end else if (ext_header_on_next) begin
            phase_next          = id3fte_pkg::PH_EXT;
            ext_bytes_left_next = '0;
          end else begin
            phase_next              = id3fte_pkg::PH_FHDR;
            frame_header_index_next = '0;
            last_was_ff_next        = 1'b0;
          end
        end
      end
      id3fte_pkg::PH_EXT: begin
        tag_bytes_left_next = tag_bytes_left - 28'd1;
        if (header_index < 4'd4) begin
          ext_bytes_left_next = {ext_bytes_left[20:0], tag_byte[6:0]};
          header_index_next   = header_index + 4'd1;
          if (header_index_next == 4'd4) begin
            if (major_version != 8'd3)
              ext_bytes_left_next = (ext_bytes_left_next >= 28'd4) ?
                                    ext_bytes_left_next - 28'd4 : '0;
            if (ext_bytes_left_next == '0) begin
              phase_next              = id3fte_pkg::PH_FHDR;
              frame_header_index_next = '0;
              last_was_ff_next        = 1'b0;
            end
          end
        end else begin
          ext_bytes_left_next = ext_bytes_left - 28'd1;
          if (ext_bytes_left_next == '0) begin
            phase_next              = id3fte_pkg::PH_FHDR;
            frame_header_index_next = '0;
            last_was_ff_next        = 1'b0;
          end
        end
        if (tag_bytes_left_next == '0) begin
          phase_next     = id3fte_pkg::PH_DONE;
          done_code_next = id3fte_pkg::OC_ABSENT;
        end
      end
      id3fte_pkg::PH_FHDR, id3fte_pkg::PH_PAY: begin
        tag_bytes_left_next = tag_bytes_left - 28'd1;
        if (unsync_on) begin
          if (last_was_ff && tag_byte == 8'h00) begin
            deliver          = 1'b0;
            last_was_ff_next = 1'b0;
          end else begin
            last_was_ff_next = (tag_byte == 8'hFF);
          end
        end
        if (deliver && phase == id3fte_pkg::PH_FHDR) begin
          idx = frame_header_index;
          if (idx == 4'd0 && (tag_byte < 8'h41 || tag_byte > 8'h5A)) begin
            phase_next     = id3fte_pkg::PH_DONE;
            done_code_next = id3fte_pkg::OC_ABSENT;
          end else begin
            if (idx == 4'd0) begin
              frame_id_shift_next = '0;
              frame_length_next   = '0;
            end
            if (idx < idlen)
              frame_id_shift_next = {frame_id_shift_next[23:0], tag_byte};
            else if (idx < idlen + idlen)
              frame_length_next = {frame_length_next[23:0], tag_byte};
            frame_header_index_next = idx + 4'd1;
            if (frame_header_index_next >= hsize) begin
              frame_header_index_next = '0;
              if (frame_length_next > {4'd0, tag_bytes_left_next}) begin
                phase_next     = id3fte_pkg::PH_DONE;
                done_code_next = id3fte_pkg::OC_ABSENT;
              end else begin
                match_found_next = shortv ?
                  (frame_id_shift_next[23:0] == short_key) :
                  (frame_id_shift_next == long_key);
                payload_index_next = '0;
                text_done_next     = 1'b0;
                text_encoding_next = '0;
                if (frame_length_next == '0) begin
                  if (match_found_next) begin
                    phase_next     = id3fte_pkg::PH_DONE;
                    done_code_next = id3fte_pkg::OC_FOUND;
                  end
                end else begin
                  phase_next = id3fte_pkg::PH_PAY;
                end
              end
            end
          end
        end else if (deliver) begin
          if (match_found) begin
            if (payload_index == '0) begin
              text_encoding_next = tag_byte;
            end else if (!text_done) begin
              plain = (text_encoding == 8'd0) || (text_encoding == 8'd3);
              take  = plain || (payload_index >= 28'd3 && payload_index[0]);
              if (take) begin
                if (tag_byte == 8'h00) begin
                  text_done_next = 1'b1;
                end else begin
                  push.r0_valid       = 1'b1;
                  push.r0.text_char   = tag_byte;
                end
              end
            end
          end
          payload_index_next = payload_index + 28'd1;
          if ({4'd0, payload_index_next} >= frame_length) begin
            if (match_found) begin
              phase_next     = id3fte_pkg::PH_DONE;
              done_code_next = id3fte_pkg::OC_FOUND;
            end else begin
              phase_next              = id3fte_pkg::PH_FHDR;
              frame_header_index_next = '0;
              last_was_ff_next        = 1'b0;
            end
          end
        end
        if (tag_bytes_left_next == '0 &&
            (phase_next == id3fte_pkg::PH_FHDR || phase_next == id3fte_pkg::PH_PAY)) begin
          done_code_next = (phase_next == id3fte_pkg::PH_PAY && match_found_next) ?
                           id3fte_pkg::OC_TRUNCATED : id3fte_pkg::OC_ABSENT;
          phase_next     = id3fte_pkg::PH_DONE;
        end
      end
      id3fte_pkg::PH_DONE, id3fte_pkg::PH_NOMAGIC: begin
      end
      default: begin
      end
    endcase

    if (end_of_data) begin
      priority if (phase_next == id3fte_pkg::PH_NOMAGIC)
        oc = id3fte_pkg::OC_NO_MAGIC;
      else if (phase_next == id3fte_pkg::PH_HDR)
        oc = (header_index_next < 4'd3) ? id3fte_pkg::OC_NO_MAGIC :
                                          id3fte_pkg::OC_TRUNCATED;
      else if (phase_next == id3fte_pkg::PH_DONE)
        oc = done_code_next;
      else if (phase_next == id3fte_pkg::PH_FHDR && frame_header_index_next == '0)
        oc = id3fte_pkg::OC_ABSENT;
      else
        oc = id3fte_pkg::OC_TRUNCATED;
      if (push.r0_valid) begin
        push.r1_valid           = 1'b1;
        push.r1.is_status       = 1'b1;
        push.r1.outcome         = oc;
        push.r1.tag_version     = major_version_next;
      end else begin
        push.r0_valid           = 1'b1;
        push.r0.is_status       = 1'b1;
        push.r0.outcome         = oc;
        push.r0.tag_version     = major_version_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_key  <= id3fte_pkg::LongKeyReset;
      short_key <= id3fte_pkg::ShortKeyReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        id3fte_pkg::RegLongKey:  long_key  <= cfg_data;
        id3fte_pkg::RegShortKey: short_key <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && end_of_data)) begin
      phase              <= id3fte_pkg::PH_HDR;
      header_index       <= '0;
      major_version      <= '0;
      unsync_on          <= 1'b0;
      ext_header_on      <= 1'b0;
      tag_bytes_left     <= '0;
      ext_bytes_left     <= '0;
      last_was_ff        <= 1'b0;
      frame_header_index <= '0;
      frame_id_shift     <= '0;
      frame_length       <= '0;
      payload_index      <= '0;
      text_encoding      <= '0;
      text_done          <= 1'b0;
      match_found        <= 1'b0;
      done_code          <= '0;
    end else if (fire) begin
      phase              <= phase_next;
      header_index       <= header_index_next;
      major_version      <= major_version_next;
      unsync_on          <= unsync_on_next;
      ext_header_on      <= ext_header_on_next;
      tag_bytes_left     <= tag_bytes_left_next;
      ext_bytes_left     <= ext_bytes_left_next;
      last_was_ff        <= last_was_ff_next;
      frame_header_index <= frame_header_index_next;
      frame_id_shift     <= frame_id_shift_next;
      frame_length       <= frame_length_next;
      payload_index      <= payload_index_next;
      text_encoding      <= text_encoding_next;
      text_done          <= text_done_next;
      match_found        <= match_found_next;
      done_code          <= done_code_next;
    end
  end

endmodule

[hw/rtl/id3fte_queue.sv]
// ----------------------------------------------------------------------------
// ID3v2 frame text extractor result queue
// Small ring of result words; takes up to two words in and one out a cycle.
// ----------------------------------------------------------------------------
module id3fte_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  id3fte_pkg::push_t                 push,
  output logic                              room,
  output logic                              out_valid,
  input  logic                              out_ready,
  output id3fte_pkg::result_t               head_word,
  output logic [id3fte_pkg::CountW-1:0]     count
);

  id3fte_pkg::result_t             slots [id3fte_pkg::QueueDepth];
  logic [id3fte_pkg::PtrW-1:0]     head;
  logic [id3fte_pkg::PtrW-1:0]     tail;
  logic [id3fte_pkg::CountW-1:0]   count_next;
  logic                            pop;
  logic                            w0;
  logic                            w1;

  assign tail      = head + count[id3fte_pkg::PtrW-1:0];
  assign room      = count <= id3fte_pkg::CountW'(id3fte_pkg::QueueDepth - 2);
  assign out_valid = count != '0;
  assign head_word = slots[head];
  assign pop       = out_valid && out_ready;
  assign w0        = fire && push.r0_valid;
  assign w1        = fire && push.r1_valid;

  always_comb begin
    count_next = count + id3fte_pkg::CountW'(w0) + id3fte_pkg::CountW'(w1)
                 - id3fte_pkg::CountW'(pop);
  end

  always_ff @(posedge clk) begin
    if (w0) slots[tail] <= push.r0;
    if (w1) slots[tail + id3fte_pkg::PtrW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + id3fte_pkg::PtrW'(1);
      count <= count_next;
    end
  end

endmodule
